/* hdl/ring_window_unwrap_address_macros.svh */
// Assertion macros for the ring window unwrap address block.
// Included by the modules that carry concurrent assertions.
`ifndef RING_WINDOW_UNWRAP_ADDRESS_MACROS_SVH
`define RING_WINDOW_UNWRAP_ADDRESS_MACROS_SVH

// same-cycle implication
`define RWUA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWUA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rwua_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ring window unwrap address block.
// No dependencies.
package rwua_pkg;

  localparam int NUM_STAGES = 9;
  localparam int FILL_W     = 32;
  localparam int SB_W       = 6;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = FILL_W / DIV_STAGES;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_TRIG   = 3'd1,
    ST_BAD_WIN   = 3'd2,
    ST_BUF_SMALL = 3'd3,
    ST_POST_MANY = 3'd4,
    ST_PRE_MANY  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CFG_BUFFER_START = 3'd0,
    CFG_WINDOW_BYTES = 3'd1,
    CFG_SAMPLE_BYTES = 3'd2,
    CFG_POST_TRIGGER = 3'd3,
    CFG_WINDOW_COUNT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic no_trig;
    logic bad_win;
    logic cap_small;
    logic post_big;
    logic pre_big;
  } err_flags_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } pipe_ctrl_t;

endpackage

/* hdl/rwua_in_if.sv */
`timescale 1ns / 1ps
// Request channel: one read request per word.
// No dependencies.
interface rwua_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  window_number;
  logic [31:0] window_fill_bytes;
  logic        window_has_trigger;
  logic [31:0] last_sample_address;
  logic [31:0] pre_wanted;
  logic [31:0] post_wanted;
  logic [31:0] dest_capacity;

  modport source (
    output valid, window_number, window_fill_bytes, window_has_trigger,
           last_sample_address, pre_wanted, post_wanted, dest_capacity,
    input  ready
  );
  modport sink (
    input  valid, window_number, window_fill_bytes, window_has_trigger,
           last_sample_address, pre_wanted, post_wanted, dest_capacity,
    output ready
  );
endinterface

/* hdl/rwua_out_if.sv */
`timescale 1ns / 1ps
// Result channel: status and up to two linear chunks per word.
// No dependencies.
interface rwua_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        wrapped;
  logic [31:0] first_address;
  logic [31:0] first_length;
  logic [31:0] second_address;
  logic [31:0] second_length;

  modport source (
    output valid, status, wrapped, first_address, first_length,
           second_address, second_length,
    input  ready
  );
  modport sink (
    input  valid, status, wrapped, first_address, first_length,
           second_address, second_length,
    output ready
  );
endinterface

/* hdl/rwua_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: fill bytes by sample width, DIV_STEPS bits per stage.
// Depends on rwua_pkg; stages advance on the shared pipeline enables.
module rwua_div import rwua_pkg::*; (
  input  logic              clk,
  input  pipe_ctrl_t        ctrl,
  input  logic [FILL_W-1:0] dividend,
  input  logic [SB_W-1:0]   divisor,
  output logic [FILL_W-1:0] quotient
);

  logic [FILL_W-1:0] num_q [DIV_STAGES];
  logic [SB_W-1:0]   rem_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [FILL_W-1:0] num_in;
    logic [FILL_W-1:0] num_next;
    logic [SB_W-1:0]   rem_in;
    logic [SB_W-1:0]   rem_next;

    if (s == 0) begin : g_first
      assign num_in = dividend;
      assign rem_in = '0;
    end else begin : g_rest
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
    end

    always_comb begin
      logic [SB_W:0] trial;
      logic [SB_W:0] diff;
      num_next = num_in;
      rem_next = rem_in;
      trial    = '0;
      diff     = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        trial    = {rem_next, num_next[FILL_W-1]};
        num_next = {num_next[FILL_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          diff        = trial - {1'b0, divisor};
          rem_next    = diff[SB_W-1:0];
          num_next[0] = 1'b1;
        end else begin
          rem_next = trial[SB_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.adv[s]) begin
        num_q[s] <= num_next;
        rem_q[s] <= rem_next;
      end
    end
  end

  assign quotient = num_q[DIV_STAGES-1];

endmodule

/* hdl/rwua_addr_pipe.sv */
`timescale 1ns / 1ps
// Check and address pipeline: request checks, trigger location with wrap, chunk split.
// Depends on rwua_pkg and the quotient from rwua_div (ready after its last stage).
module rwua_addr_pipe import rwua_pkg::*; #(
  parameter int ADDR_WIDTH  = 32,
  parameter int MAX_WINDOWS = 32
) (
  input  logic              clk,
  input  pipe_ctrl_t        ctrl,
  input  logic [4:0]        window_number,
  input  logic              window_has_trigger,
  input  logic [31:0]       last_sample_address,
  input  logic [31:0]       pre_wanted,
  input  logic [31:0]       post_wanted,
  input  logic [31:0]       dest_capacity,
  input  logic [31:0]       buffer_start,
  input  logic [31:0]       window_bytes,
  input  logic [SB_W-1:0]   sample_width,
  input  logic [31:0]       post_trigger_config,
  input  logic [SB_W-1:0]   window_count,
  input  logic [FILL_W-1:0] quotient,
  output status_t           status,
  output logic              wrapped,
  output logic [31:0]       first_address,
  output logic [31:0]       first_length,
  output logic [31:0]       second_address,
  output logic [31:0]       second_length
);

  localparam int AW = ADDR_WIDTH;
  localparam int XW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
  localparam logic [SB_W-1:0] MAX_WIN = SB_W'(MAX_WINDOWS);

  logic [AW-1:0] wb_a;
  logic [AW-1:0] w_a;
  logic [AW-1:0] ptc_a;

  assign wb_a  = AW'(window_bytes);
  assign w_a   = AW'(sample_width);
  assign ptc_a = AW'(post_trigger_config);

  // stage 0
  logic [AW-1:0] sum0, off0, tsub0;
  err_flags_t    flags0;
  logic [31:0]   last0, pre0, post0, cap0;

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      sum0           <= AW'(pre_wanted) + AW'(post_wanted);
      off0           <= wb_a * AW'(window_number);
      tsub0          <= (ptc_a + AW'(1)) * w_a;
      flags0.no_trig <= !window_has_trigger;
      flags0.bad_win <= ({1'b0, window_number} >= window_count) ||
                        ({1'b0, window_number} >= MAX_WIN);
      flags0.cap_small <= 1'b0;
      flags0.post_big  <= post_wanted > post_trigger_config;
      flags0.pre_big   <= 1'b0;
      last0          <= last_sample_address;
      pre0           <= pre_wanted;
      post0          <= post_wanted;
      cap0           <= dest_capacity;
    end
  end

  // stage 1
  logic [AW-1:0] bytes1, wstart1, tsub1;
  err_flags_t    flags1;
  logic [31:0]   last1, pre1, post1, cap1;

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      bytes1  <= sum0 * w_a;
      wstart1 <= AW'(buffer_start) + off0;
      tsub1   <= tsub0;
      flags1  <= flags0;
      last1   <= last0;
      pre1    <= pre0;
      post1   <= post0;
      cap1    <= cap0;
    end
  end

  // stage 2
  logic [AW-1:0] wlast2, wstart2, bytes2, tb2, pw2;
  err_flags_t    flags2;
  logic [31:0]   pre2;

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      wlast2           <= wstart1 + wb_a - AW'(1);
      wstart2          <= wstart1;
      bytes2           <= bytes1;
      tb2              <= AW'(last1) - tsub1;
      pw2              <= AW'(post1) * w_a;
      flags2.no_trig   <= flags1.no_trig;
      flags2.bad_win   <= flags1.bad_win;
      flags2.cap_small <= XW'(cap1) < XW'(bytes1);
      flags2.post_big  <= flags1.post_big;
      flags2.pre_big   <= flags1.pre_big;
      pre2             <= pre1;
    end
  end

  // stage 3
  logic [AW-1:0] tb3, pwm3, wlast3, wstart3, bytes3;
  err_flags_t    flags3;
  logic [31:0]   pre3;

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      tb3     <= (tb2 < wstart2) ? tb2 + wb_a : tb2;
      pwm3    <= pw2 + w_a - AW'(1);
      wlast3  <= wlast2;
      wstart3 <= wstart2;
      bytes3  <= bytes2;
      flags3  <= flags2;
      pre3    <= pre2;
    end
  end

  // stage 4
  logic [AW-1:0] lb4, avail4, wlast4, wstart4, bytes4;
  err_flags_t    flags4;
  logic [31:0]   pre4;

  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      lb4     <= tb3 + pwm3;
      avail4  <= AW'(quotient) - ptc_a;
      wlast4  <= wlast3;
      wstart4 <= wstart3;
      bytes4  <= bytes3;
      flags4  <= flags3;
      pre4    <= pre3;
    end
  end

  // stage 5
  logic [AW-1:0] lb5, wlast5, wstart5, bytes5;
  err_flags_t    flags5;

  always_ff @(posedge clk) begin
    if (ctrl.adv[5]) begin
      lb5              <= (lb4 > wlast4) ? lb4 - wb_a : lb4;
      wlast5           <= wlast4;
      wstart5          <= wstart4;
      bytes5           <= bytes4;
      flags5.no_trig   <= flags4.no_trig;
      flags5.bad_win   <= flags4.bad_win;
      flags5.cap_small <= flags4.cap_small;
      flags5.post_big  <= flags4.post_big;
      flags5.pre_big   <= XW'(pre4) > XW'(avail4);
    end
  end

  // stage 6
  logic [AW-1:0] first_lin6, sec_len6, wlast6, wstart6, bytes6;
  err_flags_t    flags6;

  always_ff @(posedge clk) begin
    if (ctrl.adv[6]) begin
      first_lin6 <= lb5 - bytes5 + AW'(1);
      sec_len6   <= lb5 - wstart5 + AW'(1);
      wlast6     <= wlast5;
      wstart6    <= wstart5;
      bytes6     <= bytes5;
      flags6     <= flags5;
    end
  end

  // stage 7
  status_t       status6;
  logic          wrapped7;
  logic [AW-1:0] first_len7, first_lin7, sec_len7, wlast7, wstart7, bytes7;
  status_t       status7;

  always_comb begin
    if (flags6.no_trig) begin
      status6 = ST_NO_TRIG;
    end else if (flags6.bad_win) begin
      status6 = ST_BAD_WIN;
    end else if (flags6.cap_small) begin
      status6 = ST_BUF_SMALL;
    end else if (flags6.post_big) begin
      status6 = ST_POST_MANY;
    end else if (flags6.pre_big) begin
      status6 = ST_PRE_MANY;
    end else begin
      status6 = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[7]) begin
      wrapped7   <= first_lin6 < wstart6;
      first_len7 <= bytes6 - sec_len6;
      first_lin7 <= first_lin6;
      sec_len7   <= sec_len6;
      wlast7     <= wlast6;
      wstart7    <= wstart6;
      bytes7     <= bytes6;
      status7    <= status6;
    end
  end

  // stage 8: result register
  logic          wrapped_next;
  logic [AW-1:0] fa_next, fl_next, sa_next, sl_next;

  always_comb begin
    wrapped_next = 1'b0;
    fa_next      = '0;
    fl_next      = '0;
    sa_next      = '0;
    sl_next      = '0;
    if (status7 == ST_OK) begin
      if (wrapped7) begin
        wrapped_next = 1'b1;
        fa_next      = wlast7 - first_len7 + AW'(1);
        fl_next      = first_len7;
        sa_next      = wstart7;
        sl_next      = sec_len7;
      end else begin
        fa_next = first_lin7;
        fl_next = bytes7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[8]) begin
      status         <= status7;
      wrapped        <= wrapped_next;
      first_address  <= 32'(fa_next);
      first_length   <= 32'(fl_next);
      second_address <= 32'(sa_next);
      second_length  <= 32'(sl_next);
    end
  end

endmodule

/* hdl/ring_window_unwrap_address.sv */
`timescale 1ns / 1ps
// Top level of the ring window unwrap address block: configuration registers,
// pipeline valid/enable control, divider and address pipeline.
// Depends on rwua_pkg, rwua_in_if, rwua_out_if, rwua_div, rwua_addr_pipe.
//
//   port   | role    | word
//   -------+---------+-----------------------------------------------
//   req    | sink    | window read request (number, fill, pointers)
//   rsp    | source  | status, wrap flag, two chunks (address, length)
//   cfg_*  | write   | index 0..4, data 32 bits, taken every enabled edge
//
// One word accepted per cycle unless a stall on rsp has backed up to req; nine
// register stages (0-8) lie between a word taken on req and its result on rsp.
// The divider fills stages 0-3 (8 quotient bits each) beside the first address
// stages; the available-sample check and the chunk split take stages 4-8.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stall on rsp backs up without loss or repeat.
// Reset clears valid bits and restores the register defaults at once.
`include "ring_window_unwrap_address_macros.svh"
module ring_window_unwrap_address import rwua_pkg::*; #(
  parameter int ADDR_WIDTH  = 32,
  parameter int MAX_WINDOWS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rwua_in_if.sink     req,
  rwua_out_if.source  rsp
);

  logic [31:0]     buffer_start;
  logic [31:0]     window_bytes;
  logic [SB_W-1:0] sample_bytes;
  logic [31:0]     post_trigger_config;
  logic [SB_W-1:0] window_count;
  logic [SB_W-1:0] sample_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_start        <= '0;
      window_bytes        <= '0;
      sample_bytes        <= SB_W'(1);
      post_trigger_config <= '0;
      window_count        <= SB_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BUFFER_START: buffer_start        <= cfg_data;
        CFG_WINDOW_BYTES: window_bytes        <= cfg_data;
        CFG_SAMPLE_BYTES: sample_bytes        <= cfg_data[SB_W-1:0];
        CFG_POST_TRIGGER: post_trigger_config <= cfg_data;
        CFG_WINDOW_COUNT: window_count        <= cfg_data[SB_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample_width = (sample_bytes == '0) ? SB_W'(1) : sample_bytes;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] adv;
  pipe_ctrl_t            ctrl;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || rsp.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_next = vld;
    if (adv[0]) begin
      vld_next[0] = req.valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctrl.adv  = adv;
  assign req.ready = adv[0];
  assign rsp.valid = vld[NUM_STAGES-1];

  logic [FILL_W-1:0] quotient;
  status_t           status;
  logic              chunks_zero;

  rwua_div u_div (
    .clk      (clk),
    .ctrl     (ctrl),
    .dividend (req.window_fill_bytes),
    .divisor  (sample_width),
    .quotient (quotient)
  );

  rwua_addr_pipe #(
    .ADDR_WIDTH  (ADDR_WIDTH),
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_addr (
    .clk                 (clk),
    .ctrl                (ctrl),
    .window_number       (req.window_number),
    .window_has_trigger  (req.window_has_trigger),
    .last_sample_address (req.last_sample_address),
    .pre_wanted          (req.pre_wanted),
    .post_wanted         (req.post_wanted),
    .dest_capacity       (req.dest_capacity),
    .buffer_start        (buffer_start),
    .window_bytes        (window_bytes),
    .sample_width        (sample_width),
    .post_trigger_config (post_trigger_config),
    .window_count        (window_count),
    .quotient            (quotient),
    .status              (status),
    .wrapped             (rsp.wrapped),
    .first_address       (rsp.first_address),
    .first_length        (rsp.first_length),
    .second_address      (rsp.second_address),
    .second_length       (rsp.second_length)
  );

  assign rsp.status = status;

  assign chunks_zero = !rsp.wrapped && (rsp.first_address == '0) &&
                       (rsp.first_length == '0) && (rsp.second_address == '0) &&
                       (rsp.second_length == '0);

  `RWUA_ASSERT_IMP(a_err_zero, clk, rst, rsp.valid && (status != ST_OK), chunks_zero, "error chunks")
  `RWUA_ASSERT_IMP(a_ready_chain, clk, rst, !rsp.valid || rsp.ready, req.ready, "req stalled")
  `RWUA_ASSERT_NXT(a_enter_stage, clk, rst, req.valid && req.ready, vld[0], "word lost")

endmodule

/* dv/tb_ring_window_unwrap_address.sv */
`timescale 1ns / 1ps
// Testbench for ring_window_unwrap_address: drives window read requests, predicts
// status and chunk addresses per request, and checks every result word in order.
// Depends on rwua_pkg, rwua_in_if, rwua_out_if and the ring_window_unwrap_address RTL.
module tb_ring_window_unwrap_address;
  import rwua_pkg::*;

  localparam int WINDOW_LIMIT = 32;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [4:0]  window_number;
    logic [31:0] window_fill_bytes;
    logic        window_has_trigger;
    logic [31:0] last_sample_address;
    logic [31:0] pre_wanted;
    logic [31:0] post_wanted;
    logic [31:0] dest_capacity;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic        wrapped;
    logic [31:0] first_address;
    logic [31:0] first_length;
    logic [31:0] second_address;
    logic [31:0] second_length;
  } chunk_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  rwua_in_if  req_ch ();
  rwua_out_if rsp_ch ();

  ring_window_unwrap_address dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // register copies used for prediction
  logic [31:0] cfg_start;
  logic [31:0] cfg_wbytes;
  logic [5:0]  cfg_sbytes;
  logic [31:0] cfg_post;
  logic [5:0]  cfg_wcount;

  request_t      pending_requests [$];
  chunk_result_t expected_chunks [$];
  request_t      held_request;
  chunk_result_t want;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_kicks;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned error_count;
  int unsigned requests_accepted;
  int unsigned results_checked;
  int unsigned settings_applied;
  int unsigned linear_ok;
  int unsigned wrapped_ok;
  int unsigned status_tally [6];

  always #4 clk = ~clk;

  function automatic chunk_result_t unwrap_chunks(request_t r);
    chunk_result_t res;
    logic [31:0] w, total, avail, wstart, wlast, trig_at, end_at, first_lin;
    logic [31:0] tail_len, head_len;
    res = '0;
    w = (cfg_sbytes == 6'd0) ? 32'd1 : {26'd0, cfg_sbytes};
    total = (r.pre_wanted + r.post_wanted) * w;
    avail = r.window_fill_bytes / w - cfg_post;
    if (!r.window_has_trigger) begin
      res.status = ST_NO_TRIG;
    end else if (r.window_number >= cfg_wcount || int'(r.window_number) >= WINDOW_LIMIT) begin
      res.status = ST_BAD_WIN;
    end else if (r.dest_capacity < total) begin
      res.status = ST_BUF_SMALL;
    end else if (r.post_wanted > cfg_post) begin
      res.status = ST_POST_MANY;
    end else if (r.pre_wanted > avail) begin
      res.status = ST_PRE_MANY;
    end else begin
      res.status = ST_OK;
      wstart = cfg_start + cfg_wbytes * {27'd0, r.window_number};
      wlast = wstart + cfg_wbytes - 32'd1;
      trig_at = r.last_sample_address - (cfg_post + 32'd1) * w;
      if (trig_at < wstart) trig_at = trig_at + cfg_wbytes;
      end_at = trig_at + r.post_wanted * w + w - 32'd1;
      if (end_at > wlast) end_at = end_at - cfg_wbytes;
      first_lin = end_at - total + 32'd1;
      if (first_lin >= wstart) begin
        res.first_address = first_lin;
        res.first_length = total;
      end else begin
        tail_len = end_at - wstart + 32'd1;
        head_len = total - tail_len;
        res.wrapped = 1'b1;
        res.first_address = wlast - head_len + 32'd1;
        res.first_length = head_len;
        res.second_address = wstart;
        res.second_length = tail_len;
      end
    end
    return res;
  endfunction

  function automatic request_t request_of(logic [4:0] win, logic [31:0] fill, logic trig,
                                          logic [31:0] last, logic [31:0] pre,
                                          logic [31:0] post, logic [31:0] cap);
    request_t r;
    r.window_number = win;
    r.window_fill_bytes = fill;
    r.window_has_trigger = trig;
    r.last_sample_address = last;
    r.pre_wanted = pre;
    r.post_wanted = post;
    r.dest_capacity = cap;
    return r;
  endfunction

  // mostly small counts, sometimes anywhere up to hi
  function automatic logic [31:0] pick_upto(logic [31:0] hi);
    logic [32:0] span;
    logic [32:0] v;
    if (hi < 32'd64 || $urandom_range(3) == 0) span = {1'b0, hi} + 33'd1;
    else span = 33'd65;
    v = {1'b0, $urandom} % span;
    return v[31:0];
  endfunction

  function automatic request_t make_request();
    request_t r;
    int unsigned kind;
    int unsigned limit;
    logic [31:0] w, avail, total, wstart;
    kind = $urandom_range(99);
    r = request_of(5'($urandom), $urandom, 1'($urandom), $urandom, $urandom,
                   $urandom, $urandom);
    if (kind >= 90) return r;
    w = (cfg_sbytes == 6'd0) ? 32'd1 : {26'd0, cfg_sbytes};
    limit = (cfg_wcount > 6'd32) ? 32 : int'(cfg_wcount);
    r.window_has_trigger = 1'b1;
    if (limit > 0) r.window_number = 5'($urandom_range(limit - 1));
    wstart = cfg_start + cfg_wbytes * {27'd0, r.window_number};
    r.last_sample_address = wstart + ((cfg_wbytes == 32'd0) ? 32'd0 : $urandom % cfg_wbytes);
    if ($urandom_range(3) != 0) r.window_fill_bytes = cfg_wbytes;
    avail = r.window_fill_bytes / w - cfg_post;
    r.post_wanted = pick_upto(cfg_post);
    r.pre_wanted = pick_upto(avail);
    total = (r.pre_wanted + r.post_wanted) * w;
    r.dest_capacity = total + $urandom_range(8);
    if (kind >= 75) begin
      case ($urandom_range(4))
        0: r.window_has_trigger = 1'b0;
        1: if (limit < 32) r.window_number = 5'($urandom_range(31, limit));
        2: r.dest_capacity = total - 32'd1;
        3: r.post_wanted = cfg_post + 32'd1;
        default: r.pre_wanted = avail + 32'd1;
      endcase
    end
    return r;
  endfunction

  function automatic void report_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (got !== exp_val)
      report_failure($sformatf("result %0d %s: expected %h, got %h",
                               results_checked, name, exp_val, got));
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_BUFFER_START: cfg_start = value;
      CFG_WINDOW_BYTES: cfg_wbytes = value;
      CFG_SAMPLE_BYTES: cfg_sbytes = value[5:0];
      CFG_POST_TRIGGER: cfg_post = value;
      CFG_WINDOW_COUNT: cfg_wcount = value[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] start, logic [31:0] wbytes, logic [31:0] sbytes,
                            logic [31:0] post, logic [31:0] count);
    write_reg(CFG_BUFFER_START, start);
    write_reg(CFG_WINDOW_BYTES, wbytes);
    write_reg(CFG_SAMPLE_BYTES, sbytes);
    write_reg(CFG_POST_TRIGGER, post);
    write_reg(CFG_WINDOW_COUNT, count);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // wait until every queued request has been answered
  task automatic drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_chunks.size() != 0);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) pending_requests.push_back(make_request());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.window_number <= '0;
      req_ch.window_fill_bytes <= '0;
      req_ch.window_has_trigger <= 1'b0;
      req_ch.last_sample_address <= '0;
      req_ch.pre_wanted <= '0;
      req_ch.post_wanted <= '0;
      req_ch.dest_capacity <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_chunks.push_back(unwrap_chunks(held_request));
        requests_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          held_request = pending_requests.pop_front();
          req_ch.window_number <= held_request.window_number;
          req_ch.window_fill_bytes <= held_request.window_fill_bytes;
          req_ch.window_has_trigger <= held_request.window_has_trigger;
          req_ch.last_sample_address <= held_request.last_sample_address;
          req_ch.pre_wanted <= held_request.pre_wanted;
          req_ch.post_wanted <= held_request.post_wanted;
          req_ch.dest_capacity <= held_request.dest_capacity;
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_served <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_checked++;
        if (expected_chunks.size() == 0) begin
          report_failure($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want = expected_chunks.pop_front();
          compare_field("status", {29'd0, want.status}, {29'd0, rsp_ch.status});
          compare_field("wrapped", {31'd0, want.wrapped}, {31'd0, rsp_ch.wrapped});
          compare_field("first_address", want.first_address, rsp_ch.first_address);
          compare_field("first_length", want.first_length, rsp_ch.first_length);
          compare_field("second_address", want.second_address, rsp_ch.second_address);
          compare_field("second_length", want.second_length, rsp_ch.second_length);
          if (want.status != ST_OK) status_tally[want.status]++;
          else if (want.wrapped) wrapped_ok++;
          else linear_ok++;
        end
      end
      // hold off the result side for a long stretch when asked
      if (hold_kicks != hold_served) begin
        hold_served <= hold_kicks;
        hold_left <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_start = 32'd0;
    cfg_wbytes = 32'd0;
    cfg_sbytes = 6'd1;
    cfg_post = 32'd0;
    cfg_wcount = 6'd1;
    send_idle_pct = 33;
    recv_stall_pct = 76;
    hold_kicks = 0;
    settings_applied = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    pending_requests.push_back(request_of(5'd0, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0));
    pending_requests.push_back(request_of(5'd31, '1, 1'b1, '1, '1, '1, '1));
    pending_requests.push_back(request_of(5'd0, '1, 1'b1, '1, 32'd0, 32'd0, 32'd0));
    drain();

    set_config(32'h0000_1000, 32'd256, 32'd4, 32'd10, 32'd8);
    pending_requests.push_back(request_of(5'd2, 32'd256, 1'b0, 32'h1200, 32'd1, 32'd1, 32'd8));
    pending_requests.push_back(request_of(5'd8, 32'd256, 1'b1, 32'h1800, 32'd1, 32'd1, 32'd8));
    pending_requests.push_back(request_of(5'd31, '1, 1'b1, '1, '1, '1, '1));
    pending_requests.push_back(request_of(5'd7, '1, 1'b1, '1, 32'd0, 32'd0, '1));
    pending_requests.push_back(request_of(5'd0, 32'd256, 1'b1, 32'h10C8, 32'd5, 32'd3, 32'd32));
    pending_requests.push_back(request_of(5'd0, 32'd256, 1'b1, 32'h10C8, 32'd5, 32'd3, 32'd31));
    pending_requests.push_back(request_of(5'd0, 32'd256, 1'b1, 32'h1014, 32'd5, 32'd3, 32'd100));
    pending_requests.push_back(request_of(5'd3, 32'd256, 1'b1, 32'h1350, 32'd0, 32'd11, 32'd1000));
    pending_requests.push_back(request_of(5'd3, 32'd256, 1'b1, 32'h1350, 32'd55, 32'd1, 32'd1000));
    pending_requests.push_back(request_of(5'd3, 32'd256, 1'b1, 32'h1350, 32'd54, 32'd1, 32'd220));
    pending_requests.push_back(request_of(5'd5, 32'd8, 1'b1, 32'h1580, 32'd1000, 32'd1, 32'd4004));
    pending_requests.push_back(request_of(5'd6, 32'd256, 1'b1, 32'h1600, 32'd0, 32'd0, 32'd0));
    pending_requests.push_back(request_of(5'd7, 32'd0, 1'b1, 32'h17FC, 32'd0, 32'd10, 32'd40));
    drain();

    // zero sample width, no windows in use
    set_config(32'h0000_0100, 32'd128, 32'd0, 32'd3, 32'd0);
    pending_requests.push_back(request_of(5'd0, 32'd128, 1'b1, 32'h120, 32'd2, 32'd2, 32'd4));
    pending_requests.push_back(request_of(5'd31, 32'd128, 1'b1, 32'h120, 32'd2, 32'd2, 32'd4));
    drain();

    // window count beyond the hardware limit
    set_config(32'h0000_0100, 32'd128, 32'd0, 32'd3, 32'd40);
    pending_requests.push_back(request_of(5'd31, 32'd128, 1'b1, 32'h0F8A, 32'd2, 32'd2, 32'd4));
    pending_requests.push_back(request_of(5'd0, 32'd128, 1'b1, 32'h0105, 32'd4, 32'd3, 32'd7));
    drain();

    for (int seg = 0; seg < 8; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 33;
        recv_stall_pct = 76;
      end else if (seg < 6) begin
        send_idle_pct = 76;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (seg)
        0: set_config(32'h0002_0000, 32'd1024, 32'd2, 32'd100, 32'd32);
        1: set_config(32'hFFFF_FF00, 32'd512, 32'd1, 32'd0, 32'd4);
        2: set_config(32'h0000_0000, 32'd64, 32'd0, 32'd5, 32'd63);
        3: set_config(32'h8000_0000, 32'd4096, 32'd32, 32'd20, 32'd1);
        4: set_config('1, '1, 32'd63, '1, 32'd33);
        5: set_config($urandom, $urandom_range(4096, 1), $urandom_range(32, 1),
                      $urandom_range(200), $urandom_range(32, 1));
        6: set_config(32'h7FFF_FFF0, 32'd0, 32'd3, 32'd0, 32'd2);
        default: set_config(32'h0000_4000, 32'd300, 32'd3, 32'd7, 32'd20);
      endcase
      if (seg == 2) begin
        // pause the sender until the block has answered everything
        queue_random(37);
        drain();
        queue_random(38);
      end else begin
        queue_random(75);
      end
      if (seg == 1 || seg == 6) hold_kicks++;
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d requests over %0d register settings, %0d results checked",
             requests_accepted, settings_applied, results_checked);
    $display("ok linear %0d, ok wrapped %0d, no trigger %0d, bad window %0d,",
             linear_ok, wrapped_ok, status_tally[ST_NO_TRIG], status_tally[ST_BAD_WIN]);
    $display("dest too small %0d, post over %0d, pre over %0d",
             status_tally[ST_BUF_SMALL], status_tally[ST_POST_MANY],
             status_tally[ST_PRE_MANY]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
